FILE: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// clocked assertion that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: src/ioa_pkg.sv
// ----------------------------------------------------------------------------
// ioa_pkg
// shared constants, status codes and scan result type
// ----------------------------------------------------------------------------
package ioa_pkg;
  localparam int MAX_POINTS = 2048;
  localparam int TIME_BITS  = 32;
  localparam int DELTA_BITS = 12;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int RUN_W      = CNT_W + DELTA_BITS + 1;
  localparam int LIM_W      = 4;
  localparam int WORD_W     = TIME_BITS + DELTA_BITS;

  localparam logic [LIM_W-1:0] MAX_OVERLAP_RESET = LIM_W'(2);
  localparam logic [DELTA_BITS-1:0] DELTA_INC = DELTA_BITS'(1);
  localparam logic [DELTA_BITS-1:0] DELTA_DEC = {DELTA_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERLAP  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_SPAN = 2'd3
  } status_t;

  typedef struct packed {
    logic              exceeded;
    logic              has_s;
    logic              has_e;
    logic [CNT_W-1:0]  pos_s;
    logic [CNT_W-1:0]  pos_e;
  } scan_res_t;
endpackage

FILE: src/ioa_in_if.sv
// ----------------------------------------------------------------------------
// ioa_in_if
// request channel: interval start and end
// ----------------------------------------------------------------------------
interface ioa_in_if import ioa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] start_time;
  logic [TIME_BITS-1:0] end_time;
  modport source (output valid, start_time, end_time, input ready);
  modport sink (input valid, start_time, end_time, output ready);
endinterface

FILE: src/ioa_out_if.sv
// ----------------------------------------------------------------------------
// ioa_out_if
// result channel: admission decision
// ----------------------------------------------------------------------------
interface ioa_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic [1:0] status;
  modport source (output valid, accepted, status, input ready);
  modport sink (input valid, accepted, status, output ready);
endinterface

FILE: src/ioa_cfg_if.sv
// ----------------------------------------------------------------------------
// ioa_cfg_if
// configuration write channel: overlap limit
// ----------------------------------------------------------------------------
interface ioa_cfg_if import ioa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: src/interval_overlap_admission.sv
// ----------------------------------------------------------------------------
// interval_overlap_admission
// admits half-open interval reservations under an overlap limit
// ----------------------------------------------------------------------------
// in_ch carries one request item (start_time, end_time); out_ch returns one
// item per request (accepted, status). cfg_ch writes the overlap limit and is
// always ready; write it only while the block is idle.
// Boundary points live in one ram of {time, delta} words. A request walks
// all N stored points, then an accepted request commits its start and
// end: a merge reads and rewrites the delta of an existing point, an insert at
// position p shifts the entries above it through the ram's one write port.
// A request with an empty or reversed span (start >= end) skips the walk;
// the time of any other is bounded by the ram walk and shift.
// One item is worked on at a time; in_ch.ready is high only when idle.
// The result sits in an output register, so the block goes idle while it
// waits; a stalled receiver holds only the completion of the next item.
// Reset empties the table (the count is cleared, the ram needs no pass)
// and sets the limit to 2.
// ----------------------------------------------------------------------------
module interval_overlap_admission import ioa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ioa_in_if.sink    in_ch,
  ioa_out_if.source out_ch,
  ioa_cfg_if.sink   cfg_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_TAIL, S_DECIDE, S_CSEL, S_MRD, S_MWR, S_SHIFT, S_INS, S_RESP
  } state_t;

  state_t               state_r;
  logic [TIME_BITS-1:0] s_r, e_r;
  logic [CNT_W-1:0]     count_r, ptr_r, pos_r;
  logic [ADDR_W-1:0]    pend_addr_r;
  logic                 pend_r, rvld_r, phase_r;
  status_t              status_r;
  logic [LIM_W-1:0]     max_overlap_r;
  logic                 out_valid_r, out_acc_r;
  status_t              out_status_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;
  logic [TIME_BITS-1:0] rd_time, cur_time;
  logic [DELTA_BITS-1:0] rd_delta, cur_step;
  scan_res_t            scan;
  logic                 in_acc, cur_has;
  logic [CNT_W-1:0]     cur_pos;
  logic [1:0]           needed;
  logic [CNT_W:0]       fill;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.accepted = out_acc_r;
  assign out_ch.status = out_status_r;

  assign rd_time  = ram_rdata[WORD_W-1:DELTA_BITS];
  assign rd_delta = ram_rdata[DELTA_BITS-1:0];
  assign cur_time = phase_r ? e_r : s_r;
  assign cur_step = phase_r ? DELTA_DEC : DELTA_INC;
  assign cur_has  = phase_r ? scan.has_e : scan.has_s;
  assign cur_pos  = phase_r ? scan.pos_e + CNT_W'(!scan.has_s) : scan.pos_s;
  assign needed   = 2'(!scan.has_s) + 2'(!scan.has_e);
  assign fill     = {1'b0, count_r} + (CNT_W+1)'(needed);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_r[ADDR_W-1:0];
    ram_wdata = {cur_time, cur_step};
    ram_raddr = ptr_r[ADDR_W-1:0];
    unique case (state_r)
      S_CSEL:  ram_raddr = cur_pos[ADDR_W-1:0];
      S_MRD:   ram_raddr = pos_r[ADDR_W-1:0];
      S_MWR: begin
        ram_we    = 1'b1;
        ram_wdata = {rd_time, rd_delta + cur_step};
      end
      S_SHIFT: begin
        ram_raddr = ptr_r[ADDR_W-1:0] - ADDR_W'(1);
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
      end
      S_INS:   ram_we = 1'b1;
      default: ;
    endcase
  end

  ioa_ram #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ioa_scan u_scan (
    .clk (clk),
    .clr (in_acc),
    .en  (state_r == S_WALK && rvld_r),
    .fin (state_r == S_TAIL),
    .s   (s_r),
    .e   (e_r),
    .t   (rd_time),
    .d   (rd_delta),
    .lim (max_overlap_r),
    .res (scan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      count_r       <= '0;
      max_overlap_r <= MAX_OVERLAP_RESET;
      out_valid_r   <= 1'b0;
      rvld_r        <= 1'b0;
      pend_r        <= 1'b0;
      phase_r       <= 1'b0;
    end else begin
      if (cfg_ch.valid) max_overlap_r <= cfg_ch.data;
      if (state_r == S_RESP && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            s_r    <= in_ch.start_time;
            e_r    <= in_ch.end_time;
            ptr_r  <= '0;
            rvld_r <= 1'b0;
            if (in_ch.start_time >= in_ch.end_time) begin
              status_r <= ST_BAD_SPAN;
              state_r  <= S_RESP;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_WALK: begin
          rvld_r <= (ptr_r < count_r);
          if (ptr_r < count_r) ptr_r <= ptr_r + CNT_W'(1);
          else if (!rvld_r) state_r <= S_TAIL;
        end
        S_TAIL: state_r <= S_DECIDE;
        S_DECIDE: begin
          phase_r <= 1'b0;
          if (fill > (CNT_W+1)'(MAX_POINTS)) begin
            status_r <= ST_FULL;
            state_r  <= S_RESP;
          end else if (scan.exceeded) begin
            status_r <= ST_OVERLAP;
            state_r  <= S_RESP;
          end else begin
            status_r <= ST_OK;
            state_r  <= S_CSEL;
          end
        end
        S_CSEL: begin
          pos_r  <= cur_pos;
          ptr_r  <= count_r;
          pend_r <= 1'b0;
          state_r <= cur_has ? S_MRD : S_SHIFT;
        end
        S_MRD: state_r <= S_MWR;
        S_MWR: begin
          phase_r <= 1'b1;
          state_r <= phase_r ? S_RESP : S_CSEL;
        end
        S_SHIFT: begin
          if (ptr_r > pos_r) begin
            pend_r      <= 1'b1;
            pend_addr_r <= ptr_r[ADDR_W-1:0];
            ptr_r       <= ptr_r - CNT_W'(1);
          end else begin
            pend_r  <= 1'b0;
            state_r <= S_INS;
          end
        end
        S_INS: begin
          count_r <= count_r + CNT_W'(1);
          phase_r <= 1'b1;
          state_r <= phase_r ? S_RESP : S_CSEL;
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            out_acc_r    <= (status_r == ST_OK);
            out_status_r <= status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: src/ioa_ram.sv
// ----------------------------------------------------------------------------
// ioa_ram
// generic simple dual port ram, registered read
// ----------------------------------------------------------------------------
module ioa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: src/ioa_scan.sv
// ----------------------------------------------------------------------------
// ioa_scan
// running overlap sum and insert positions over one walk of the table
// ----------------------------------------------------------------------------
module ioa_scan import ioa_pkg::*; (
  input  logic                  clk,
  input  logic                  clr,
  input  logic                  en,
  input  logic                  fin,
  input  logic [TIME_BITS-1:0]  s,
  input  logic [TIME_BITS-1:0]  e,
  input  logic [TIME_BITS-1:0]  t,
  input  logic [DELTA_BITS-1:0] d,
  input  logic [LIM_W-1:0]      lim,
  output scan_res_t             res
);
  logic signed [RUN_W-1:0] run_r, run_nxt;
  logic                    sd_r, sd_nxt, ed_r, ed_nxt;
  scan_res_t               res_r, res_nxt;
  logic signed [RUN_W-1:0] lim_s;

  assign lim_s = $signed({{(RUN_W-LIM_W){1'b0}}, lim});
  assign res   = res_r;

  always_comb begin
    run_nxt = run_r;
    sd_nxt  = sd_r;
    ed_nxt  = ed_r;
    res_nxt = res_r;
    if (clr) begin
      run_nxt = '0;
      sd_nxt  = 1'b0;
      ed_nxt  = 1'b0;
      res_nxt = '0;
    end else if (en) begin
      if (t < s) res_nxt.pos_s = res_r.pos_s + CNT_W'(1);
      if (t < e) res_nxt.pos_e = res_r.pos_e + CNT_W'(1);
      if (t == s) res_nxt.has_s = 1'b1;
      if (t == e) res_nxt.has_e = 1'b1;
      if (!sd_nxt && s < t) begin
        run_nxt = run_nxt + RUN_W'(1);
        sd_nxt  = 1'b1;
        if (run_nxt > lim_s) res_nxt.exceeded = 1'b1;
      end
      if (!ed_nxt && e < t) begin
        run_nxt = run_nxt - RUN_W'(1);
        ed_nxt  = 1'b1;
        if (run_nxt > lim_s) res_nxt.exceeded = 1'b1;
      end
      run_nxt = run_nxt + RUN_W'($signed(d));
      if (!sd_nxt && s == t) begin
        run_nxt = run_nxt + RUN_W'(1);
        sd_nxt  = 1'b1;
      end
      if (!ed_nxt && e == t) begin
        run_nxt = run_nxt - RUN_W'(1);
        ed_nxt  = 1'b1;
      end
      if (run_nxt > lim_s) res_nxt.exceeded = 1'b1;
    end else if (fin) begin
      if (!sd_nxt) begin
        run_nxt = run_nxt + RUN_W'(1);
        sd_nxt  = 1'b1;
        if (run_nxt > lim_s) res_nxt.exceeded = 1'b1;
      end
      if (!ed_nxt) begin
        run_nxt = run_nxt - RUN_W'(1);
        ed_nxt  = 1'b1;
        if (run_nxt > lim_s) res_nxt.exceeded = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_r <= run_nxt;
    sd_r  <= sd_nxt;
    ed_r  <= ed_nxt;
    res_r <= res_nxt;
  end
endmodule

FILE: src/ioa_checker.sv
// ----------------------------------------------------------------------------
// ioa_checker
// port level checks of the admission block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ioa_checker import ioa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_accepted,
  input logic [1:0] out_status
);
  // one item at a time
  `ASSERT_CLK(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  // accepted flag agrees with status
  `ASSERT_CLK(a_acc_status, clk, rst_n, out_valid |-> (out_accepted == (out_status == ST_OK)))
  // stalled result stays valid and keeps its status
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
  // no result right after reset
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)
endmodule

bind interval_overlap_admission ioa_checker u_ioa_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_accepted (out_ch.accepted),
  .out_status   (out_ch.status)
);
